FILE: src/display_list_face_extractor_macros.svh
// Assertion helpers for the display list face extractor.
// Each helper checks on the rising clock edge and is off while reset is held.
`ifndef DISPLAY_LIST_FACE_EXTRACTOR_MACROS_SVH
`define DISPLAY_LIST_FACE_EXTRACTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("display list face extractor: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DLFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("display list face extractor: next-cycle check failed");

`endif

FILE: src/dlfe_pkg.sv
`timescale 1ns / 1ps

package dlfe_pkg;

	localparam int unsigned CMD_W            = 64;
	localparam int unsigned VC_W             = 13;
	localparam int unsigned VIDX_W           = 12;
	localparam int unsigned CACHE_SLOTS      = 16;
	localparam int unsigned SLOT_W           = 4;
	localparam int unsigned MAX_VERTICES_DEF = 4096;

	// Result queue: one bank per result a single command can produce.
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned QUEUE_ROWS  = 4;
	localparam int unsigned QUEUE_CAP   = MAX_RESULTS * QUEUE_ROWS;
	localparam int unsigned BANK_W      = $clog2(MAX_RESULTS);
	localparam int unsigned ROW_W       = $clog2(QUEUE_ROWS);
	localparam int unsigned QPTR_W      = BANK_W + ROW_W;
	localparam int unsigned QLVL_W      = $clog2(QUEUE_CAP + 1);
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] OP_NOOP     = 8'hC0;
	localparam logic [7:0] OP_VTX      = 8'h04;
	localparam logic [7:0] OP_TRI4     = 8'hB1;
	localparam logic [7:0] OP_CLEARGEO = 8'hB6;
	localparam logic [7:0] OP_SETGEO   = 8'hB7;
	localparam logic [7:0] OP_END      = 8'hB8;
	localparam logic [7:0] OP_TRI1     = 8'hBF;

	localparam int unsigned CULL_BIT  = 13;
	localparam logic [15:0] GROUP_MAX = 16'hFFFF;

	localparam logic KIND_FACE = 1'b0;
	localparam logic KIND_KEPT = 1'b1;

	// x / 10 for any 8-bit x equals (x * 205) >> 11.
	localparam logic [15:0] DIV10_MUL   = 16'd205;
	localparam int unsigned DIV10_SHIFT = 11;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             last_of_list;
	} cmd_item_t;

	typedef struct packed {
		logic              result_kind;
		logic [31:0]       face_id;
		logic [VIDX_W-1:0] vertex_a;
		logic [VIDX_W-1:0] vertex_b;
		logic [VIDX_W-1:0] vertex_c;
		logic [15:0]       draw_group;
		logic [31:0]       texture_high;
		logic [31:0]       texture_low;
		logic              cull_back;
		logic [CMD_W-1:0]  kept_command;
		logic              last_result;
	} res_item_t;

	// All results of one command, packed from index 0 upward.
	typedef struct packed {
		res_item_t [MAX_RESULTS-1:0] item;
		logic [CNT_W-1:0]            count;
	} res_batch_t;

	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              near_full;
	} rq_status_t;

	function automatic logic [SLOT_W:0] div10(input logic [7:0] x);
		logic [15:0] prod;
		prod = 16'(x) * DIV10_MUL;
		return prod[DIV10_SHIFT +: SLOT_W + 1];
	endfunction

endpackage

FILE: src/dlfe_decode.sv
`timescale 1ns / 1ps

module dlfe_decode #(
	parameter int unsigned MAX_VERTICES = dlfe_pkg::MAX_VERTICES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_take,
	input  dlfe_pkg::cmd_item_t          cmd_data,
	input  logic                         cfg_wr_en,
	input  logic [dlfe_pkg::VC_W-1:0]    cfg_wr_data,
	output dlfe_pkg::res_batch_t         batch
);

	localparam int unsigned VC_W_FIX = dlfe_pkg::VC_W;
	localparam int unsigned VC_MAX  = (2 ** dlfe_pkg::VC_W) - 1;
	localparam int unsigned LIM_CAP = (MAX_VERTICES > VC_MAX) ? VC_MAX : MAX_VERTICES;
	localparam int unsigned NSLOT   = dlfe_pkg::CACHE_SLOTS;
	localparam int unsigned SW      = dlfe_pkg::SLOT_W;
	localparam int unsigned VW      = dlfe_pkg::VIDX_W;
	localparam int unsigned NR      = dlfe_pkg::MAX_RESULTS;
	localparam int unsigned CW      = dlfe_pkg::CNT_W;

	logic                          vld_s1;
	logic [dlfe_pkg::CMD_W-1:0]    cmd_s1;
	logic                          last_s1;

	logic [dlfe_pkg::VC_W-1:0]     vcount_q;
	logic [VW-1:0]                 slot_vert_q [NSLOT];
	logic [NSLOT-1:0]              slot_valid_q;
	logic [31:0]                   tex_hi_q;
	logic [31:0]                   tex_lo_q;
	logic                          cull_q;
	logic [15:0]                   group_q;
	logic                          has_faces_q;
	logic                          ended_q;
	logic [31:0]                   next_face_q;

	logic [7:0]                    op;
	logic                          live;
	logic                          is_end;
	logic                          is_vtx;
	logic                          is_tri1;
	logic                          is_tri4;
	logic                          is_tri;
	logic                          is_kept;

	logic [VC_W_FIX-1:0]           lim;
	logic [19:0]                   ld_first;
	logic [19:0]                   ld_room;
	logic [4:0]                    ld_cnt;
	logic [SW-1:0]                 ld_v0;
	logic                          ld_bad;
	logic                          ld_en;
	logic [NSLOT-1:0]              ld_hit;
	logic [VW-1:0]                 ld_val [NSLOT];

	logic [SW:0]                   ia [NR];
	logic [SW:0]                   ib [NR];
	logic [SW:0]                   ic [NR];
	logic [31:0]                   fid [NR];
	logic [NR-1:0]                 emit;
	logic [CW-1:0]                 n_cand;
	logic [CW-1:0]                 n_face;
	logic [32:0]                   face_total;
	logic [31:0]                   next_face_nxt;
	logic [15:0]                   group_nxt;

	// Input register: the command is decoded against the state in the cycle after it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_s1  <= cmd_data.command;
			last_s1 <= cmd_data.last_of_list;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	assign op      = cmd_s1[63:56];
	assign live    = vld_s1 && !ended_q;
	assign is_end  = (op == dlfe_pkg::OP_END);
	assign is_vtx  = (op == dlfe_pkg::OP_VTX);
	assign is_tri1 = (op == dlfe_pkg::OP_TRI1);
	assign is_tri4 = (op == dlfe_pkg::OP_TRI4);
	assign is_tri  = is_tri1 || is_tri4;
	assign is_kept = !(is_end || is_vtx || is_tri);

	// Vertex load: alignment and range checks against the clamped vertex count and the cache slots.
	assign lim = (vcount_q > VC_W_FIX'(LIM_CAP)) ? VC_W_FIX'(LIM_CAP) : vcount_q;
	assign ld_first = cmd_s1[23:4];
	assign ld_room  = 20'(lim) - ld_first;
	assign ld_cnt   = {1'b0, cmd_s1[55:52]} + 5'd1;
	assign ld_v0    = cmd_s1[51:48];
	assign ld_bad   = (cmd_s1[3:0] != 4'd0) || (ld_first >= 20'(lim))
			|| (20'(ld_cnt) > ld_room) || ((5'(ld_v0) + ld_cnt) > 5'(NSLOT));
	assign ld_en    = live && is_vtx && !ld_bad;

	always_comb begin
		for (int s = 0; s < NSLOT; s++) begin
			ld_hit[s] = ld_en && (5'(s) >= 5'(ld_v0)) && (5'(s) < (5'(ld_v0) + ld_cnt));
			ld_val[s] = ld_first[VW-1:0] + VW'(s) - VW'(ld_v0);
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < NSLOT; s++) begin
			if (ld_hit[s]) begin
				slot_vert_q[s] <= ld_val[s];
			end
		end
	end

	// Triangle corners, validity and face numbering.
	always_comb begin
		logic [CW-1:0] cp;
		logic [32:0]   sum;
		logic [7:0]    pb;
		logic [7:0]    tb;
		logic          cand;
		cp = '0;
		for (int t = 0; t < NR; t++) begin
			pb = cmd_s1[8*t +: 8];
			tb = t[1] ? cmd_s1[47:40] : cmd_s1[39:32];
			if (is_tri1) begin
				ia[t] = dlfe_pkg::div10(cmd_s1[23:16]);
				ib[t] = dlfe_pkg::div10(cmd_s1[15:8]);
				ic[t] = dlfe_pkg::div10(cmd_s1[7:0]);
			end else begin
				ia[t] = {1'b0, pb[3:0]};
				ib[t] = {1'b0, pb[7:4]};
				ic[t] = t[0] ? {1'b0, tb[7:4]} : {1'b0, tb[3:0]};
			end
			cand = live && is_tri && (is_tri4 || (t == 0))
				&& !(is_tri4 && (ia[t] == '0) && (ib[t] == '0) && (ic[t] == '0))
				&& !ia[t][SW] && !ib[t][SW] && !ic[t][SW]
				&& slot_valid_q[ia[t][SW-1:0]] && slot_valid_q[ib[t][SW-1:0]]
				&& slot_valid_q[ic[t][SW-1:0]];
			sum = {1'b0, next_face_q} + 33'(cp);
			fid[t] = sum[31:0];
			emit[t] = cand && (next_face_q != 32'd0) && !sum[32];
			if (cand) begin
				cp = cp + CW'(1);
			end
		end
		n_cand = cp;
	end

	always_comb begin
		n_face = '0;
		for (int t = 0; t < NR; t++) begin
			n_face = n_face + CW'(emit[t]);
		end
	end

	// Once the identity counter wraps to zero it stays there.
	assign face_total    = {1'b0, next_face_q} + 33'(n_cand);
	assign next_face_nxt = ((next_face_q == 32'd0) || face_total[32]) ? 32'd0 : face_total[31:0];

	assign group_nxt = (has_faces_q && (group_q != dlfe_pkg::GROUP_MAX))
			? group_q + 16'd1 : group_q;

	always_comb begin
		logic [CW-1:0] k;
		batch = '0;
		k = '0;
		if (live && is_kept) begin
			batch.count                     = CW'(1);
			batch.item[0].result_kind       = dlfe_pkg::KIND_KEPT;
			batch.item[0].draw_group        = group_nxt;
			batch.item[0].kept_command      = cmd_s1;
			batch.item[0].last_result       = 1'b1;
		end else begin
			batch.count = n_face;
			for (int t = 0; t < NR; t++) begin
				if (emit[t]) begin
					batch.item[k[dlfe_pkg::BANK_W-1:0]] = '{
						result_kind:  dlfe_pkg::KIND_FACE,
						face_id:      fid[t],
						vertex_a:     slot_vert_q[ia[t][SW-1:0]],
						vertex_b:     slot_vert_q[ib[t][SW-1:0]],
						vertex_c:     slot_vert_q[ic[t][SW-1:0]],
						draw_group:   group_q,
						texture_high: tex_hi_q,
						texture_low:  tex_lo_q,
						cull_back:    cull_q,
						kept_command: '0,
						last_result:  (k == (n_face - CW'(1)))
					};
					k = k + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			tex_hi_q     <= '0;
			tex_lo_q     <= '0;
			cull_q       <= 1'b0;
			group_q      <= '0;
			has_faces_q  <= 1'b0;
			ended_q      <= 1'b0;
			next_face_q  <= 32'd1;
		end else if (vld_s1) begin
			if (live && is_tri) begin
				next_face_q <= next_face_nxt;
			end
			// The end of a list returns everything but the face counter and the vertex count to reset.
			if (last_s1) begin
				slot_valid_q <= '0;
				tex_hi_q     <= '0;
				tex_lo_q     <= '0;
				cull_q       <= 1'b0;
				group_q      <= '0;
				has_faces_q  <= 1'b0;
				ended_q      <= 1'b0;
			end else begin
				if (live && is_end) begin
					ended_q <= 1'b1;
				end
				if (ld_en) begin
					slot_valid_q <= slot_valid_q | ld_hit;
				end
				if (live && is_tri && (|emit)) begin
					has_faces_q <= 1'b1;
				end
				if (live && is_kept) begin
					group_q     <= group_nxt;
					has_faces_q <= 1'b0;
					if (op == dlfe_pkg::OP_NOOP) begin
						tex_hi_q <= cmd_s1[63:32];
						tex_lo_q <= cmd_s1[31:0];
					end else if ((op == dlfe_pkg::OP_SETGEO) && cmd_s1[dlfe_pkg::CULL_BIT]) begin
						cull_q <= 1'b1;
					end else if ((op == dlfe_pkg::OP_CLEARGEO) && cmd_s1[dlfe_pkg::CULL_BIT]) begin
						cull_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

FILE: src/dlfe_rqueue.sv
`timescale 1ns / 1ps

module dlfe_rqueue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlfe_pkg::res_batch_t  wr,
	output logic                  res_valid,
	input  logic                  res_stall,
	output dlfe_pkg::res_item_t   res_data,
	output dlfe_pkg::rq_status_t  stat
);

	localparam int unsigned NB  = dlfe_pkg::MAX_RESULTS;
	localparam int unsigned BW  = dlfe_pkg::BANK_W;
	localparam int unsigned PW  = dlfe_pkg::QPTR_W;
	localparam int unsigned LW  = dlfe_pkg::QLVL_W;
	localparam int unsigned CW  = dlfe_pkg::CNT_W;
	localparam int unsigned CAP = dlfe_pkg::QUEUE_CAP;

	logic [PW-1:0]        wp_q;
	logic [PW-1:0]        rp_q;
	logic [LW-1:0]        level_q;
	logic                 out_vld_q;
	logic [BW-1:0]        sel_q;
	dlfe_pkg::res_item_t  rdata_q [NB];
	logic                 pop;
	logic                 rd_en;

	assign pop   = out_vld_q && !res_stall;
	// Only entries written at an earlier edge are read, so a read never meets a write.
	assign rd_en = (level_q != '0) && (!out_vld_q || pop);

	// Result j of a command goes to bank (wp + j) mod NB, so no bank sees two writes.
	for (genvar b = 0; b < NB; b++) begin : g_bank
		localparam logic [BW-1:0] BANK = BW'(b);
		dlfe_pkg::res_item_t  mem [dlfe_pkg::QUEUE_ROWS];
		logic [BW-1:0]        slot_j;
		logic [PW-1:0]        waddr;
		logic                 we;

		assign slot_j = BANK - wp_q[BW-1:0];
		assign waddr  = wp_q + PW'(slot_j);
		assign we     = CW'(slot_j) < wr.count;

		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr[PW-1:BW]] <= wr.item[slot_j];
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en && (rp_q[BW-1:0] == BANK)) begin
				rdata_q[b] <= mem[rp_q[PW-1:BW]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			level_q   <= '0;
			out_vld_q <= 1'b0;
			sel_q     <= '0;
		end else begin
			wp_q    <= wp_q + PW'(wr.count);
			level_q <= level_q + LW'(wr.count) - LW'(rd_en);
			if (rd_en) begin
				rp_q      <= rp_q + PW'(1);
				sel_q     <= rp_q[BW-1:0];
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign res_valid      = out_vld_q;
	assign res_data       = rdata_q[sel_q];
	assign stat.level     = level_q;
	// Room must remain for the command in decode and one more behind it.
	assign stat.near_full = level_q > LW'(CAP - 2 * NB);

endmodule

FILE: src/display_list_face_extractor.sv
`timescale 1ns / 1ps
// Display list face extractor.
// The command channel (cmd_valid, cmd_stall, cmd_data) takes one 64-bit display-list
// command per beat with a last_of_list mark. The result channel (res_valid, res_stall,
// res_data) gives faces and passed-through commands, one per beat, last_result set on
// the final result of each command. cfg_wr_en/cfg_wr_data write the vertex count.
// A command is taken every cycle while at most eight results wait in the queue; the
// first result of a command passes the input register, a queue bank and the output
// register before it appears on res_valid. A four-triangle command writes up to four
// results in the same cycle into a 16-entry banked result queue (four banks, each with
// one write and one read port), which then drains one result a cycle while res_stall is low.
// When the receiver stalls, the current result holds steady, the queue fills, and
// cmd_stall rises once more than eight results are waiting.
// Reset clears the vertex cache marks, the texture words, cull mode, draw group,
// the face counter (back to one), the vertex count and the result queue; no clearing
// pass is needed and commands are taken from the first cycle after reset.
module display_list_face_extractor #(
	parameter int unsigned MAX_VERTICES = dlfe_pkg::MAX_VERTICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  dlfe_pkg::cmd_item_t        cmd_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output dlfe_pkg::res_item_t        res_data,
	input  logic                       cfg_wr_en,
	input  logic [dlfe_pkg::VC_W-1:0]  cfg_wr_data
);

	`include "display_list_face_extractor_macros.svh"

	logic                  cmd_take;
	dlfe_pkg::res_batch_t  batch;
	dlfe_pkg::rq_status_t  q_stat;

	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cmd_stall = q_stat.near_full;

	dlfe_decode #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_take   (cmd_take),
		.cmd_data   (cmd_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.batch      (batch)
	);

	dlfe_rqueue u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (batch),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data),
		.stat     (q_stat)
	);

	`DLFE_ASSERT_SAME(a_queue_bound, clk, arst_n, 1'b1, q_stat.level <= dlfe_pkg::QLVL_W'(dlfe_pkg::QUEUE_CAP))
	`DLFE_ASSERT_NEXT(a_accept_room, clk, arst_n, cmd_take, q_stat.level <= dlfe_pkg::QLVL_W'(dlfe_pkg::QUEUE_CAP - dlfe_pkg::MAX_RESULTS))
	`DLFE_ASSERT_SAME(a_multi_is_face, clk, arst_n, batch.count > dlfe_pkg::CNT_W'(1), batch.item[0].result_kind == dlfe_pkg::KIND_FACE)
	`DLFE_ASSERT_SAME(a_face_ids_consecutive, clk, arst_n, (batch.count > dlfe_pkg::CNT_W'(1)) && (batch.item[0].result_kind == dlfe_pkg::KIND_FACE), batch.item[1].face_id == batch.item[0].face_id + 32'd1)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned QUIET_LIMIT   = 1000;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned BURST_ITEMS   = 22;
	localparam logic [7:0]  OP_OTHER      = 8'hFC;

	logic                          clk;
	logic                          arst_n;
	logic                          cmd_valid;
	logic                          cmd_stall;
	dlfe_pkg::cmd_item_t           cmd_data;
	logic                          res_valid;
	logic                          res_stall;
	dlfe_pkg::res_item_t           res_data;
	logic                          cfg_wr_en;
	logic [dlfe_pkg::VC_W-1:0]     cfg_wr_data;

	display_list_face_extractor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_data   (cmd_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Shadow copy of the decoder state.
	logic [dlfe_pkg::VIDX_W-1:0]   cache_vertex [dlfe_pkg::CACHE_SLOTS];
	bit                            cache_filled [dlfe_pkg::CACHE_SLOTS];
	logic [31:0]                   tex_hi;
	logic [31:0]                   tex_lo;
	bit                            cull_on;
	logic [15:0]                   group_no;
	bit                            group_used;
	bit                            list_done;
	logic [31:0]                   face_counter;
	logic [dlfe_pkg::VC_W-1:0]     vcount;

	dlfe_pkg::res_item_t predicted_results [$];
	dlfe_pkg::res_item_t head_result;
	int        errors = 0;
	int        quiet_cycles = 0;
	bit        idle_en;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_list();
		int i;
		for (i = 0; i < dlfe_pkg::CACHE_SLOTS; i++) begin
			cache_vertex[i] = '0;
			cache_filled[i] = 1'b0;
		end
		tex_hi = '0;
		tex_lo = '0;
		cull_on = 1'b0;
		group_no = '0;
		group_used = 1'b0;
		list_done = 1'b0;
	endfunction

	function automatic int unsigned table_limit();
		return (32'(vcount) > dlfe_pkg::MAX_VERTICES_DEF)
			? dlfe_pkg::MAX_VERTICES_DEF : 32'(vcount);
	endfunction

	// Works out the faces or the kept command that one command beat yields.
	function automatic void extract_faces(input logic [dlfe_pkg::CMD_W-1:0] c,
			input logic last);
		dlfe_pkg::res_item_t outs [dlfe_pkg::MAX_RESULTS];
		dlfe_pkg::res_item_t r;
		int          n;
		int          i;
		int          t;
		int          k;
		int unsigned base;
		int unsigned cnt;
		int unsigned v0;
		int unsigned lim;
		int unsigned tris;
		int unsigned idx [3];
		logic [7:0]  op;
		logic [7:0]  pair;
		logic [7:0]  third;
		bit          ok;
		n = 0;
		op = c[63:56];
		if (!list_done) begin
			if (op == dlfe_pkg::OP_END) begin
				list_done = 1'b1;
			end else if (op == dlfe_pkg::OP_VTX) begin
				base = 32'(c[23:4]);
				cnt = 32'(c[55:52]) + 1;
				v0 = 32'(c[51:48]);
				lim = table_limit();
				if (c[3:0] == 4'h0 && base < lim && cnt <= lim - base
						&& v0 + cnt <= dlfe_pkg::CACHE_SLOTS) begin
					for (i = 0; i < cnt; i++) begin
						cache_vertex[(v0 + i) % dlfe_pkg::CACHE_SLOTS] =
							dlfe_pkg::VIDX_W'(base + i);
						cache_filled[(v0 + i) % dlfe_pkg::CACHE_SLOTS] = 1'b1;
					end
				end
			end else if (op == dlfe_pkg::OP_TRI1 || op == dlfe_pkg::OP_TRI4) begin
				tris = (op == dlfe_pkg::OP_TRI1) ? 1 : dlfe_pkg::MAX_RESULTS;
				for (t = 0; t < tris; t++) begin
					if (op == dlfe_pkg::OP_TRI1) begin
						idx[0] = 32'(c[23:16]) / 10;
						idx[1] = 32'(c[15:8]) / 10;
						idx[2] = 32'(c[7:0]) / 10;
					end else begin
						pair = c[8*t +: 8];
						third = c[32 + 8*(t/2) +: 8];
						idx[0] = 32'(pair[3:0]);
						idx[1] = 32'(pair[7:4]);
						idx[2] = t[0] ? 32'(third[7:4]) : 32'(third[3:0]);
					end
					// An all-zero packed entry is an empty slot, not a face.
					ok = (op == dlfe_pkg::OP_TRI1) || idx[0] != 0 || idx[1] != 0
						|| idx[2] != 0;
					for (k = 0; k < 3; k++)
						if (idx[k] >= dlfe_pkg::CACHE_SLOTS
								|| !cache_filled[idx[k] % dlfe_pkg::CACHE_SLOTS])
							ok = 1'b0;
					if (ok && face_counter != 0) begin
						r = '0;
						r.result_kind = dlfe_pkg::KIND_FACE;
						r.face_id = face_counter;
						r.vertex_a = cache_vertex[idx[0]];
						r.vertex_b = cache_vertex[idx[1]];
						r.vertex_c = cache_vertex[idx[2]];
						r.draw_group = group_no;
						r.texture_high = tex_hi;
						r.texture_low = tex_lo;
						r.cull_back = cull_on;
						outs[n] = r;
						n++;
						face_counter++;
						group_used = 1'b1;
					end
				end
			end else begin
				if (group_used) begin
					if (group_no != dlfe_pkg::GROUP_MAX)
						group_no++;
					group_used = 1'b0;
				end
				r = '0;
				r.result_kind = dlfe_pkg::KIND_KEPT;
				r.draw_group = group_no;
				r.kept_command = c;
				outs[0] = r;
				n = 1;
				if (op == dlfe_pkg::OP_NOOP) begin
					tex_hi = c[63:32];
					tex_lo = c[31:0];
				end else if (op == dlfe_pkg::OP_SETGEO && c[dlfe_pkg::CULL_BIT]) begin
					cull_on = 1'b1;
				end else if (op == dlfe_pkg::OP_CLEARGEO && c[dlfe_pkg::CULL_BIT]) begin
					cull_on = 1'b0;
				end
			end
		end
		if (n > 0)
			outs[n-1].last_result = 1'b1;
		for (i = 0; i < n; i++)
			predicted_results.push_back(outs[i]);
		if (last)
			clear_list();
	endfunction

	task automatic send_command(input logic [dlfe_pkg::CMD_W-1:0] c, input logic last);
		dlfe_pkg::cmd_item_t item;
		item.command = c;
		item.last_of_list = last;
		while (idle_en && $urandom_range(99) < 23) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= item;
		extract_faces(c, last);
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
	endtask

	task automatic wait_until_idle();
		cmd_valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		// Vertex loads leave no result behind, so give the pipeline time to finish them.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int unsigned value);
		wait_until_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= dlfe_pkg::VC_W'(value);
		vcount = dlfe_pkg::VC_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [dlfe_pkg::CMD_W-1:0] random_load();
		logic [dlfe_pkg::CMD_W-1:0] c;
		int unsigned      lim;
		int unsigned      cnt;
		int unsigned      v0;
		int unsigned      base;
		lim = table_limit();
		c = {dlfe_pkg::OP_VTX, 8'h00, 24'($urandom), 24'h0};
		if ($urandom_range(9) == 0 || lim == 0) begin
			c[55:48] = 8'($urandom);
			c[23:0] = 24'($urandom);
		end else begin
			cnt = (lim < dlfe_pkg::CACHE_SLOTS) ? lim : dlfe_pkg::CACHE_SLOTS;
			if ($urandom_range(1) == 0)
				cnt = $urandom_range(1, cnt);
			v0 = $urandom_range(0, dlfe_pkg::CACHE_SLOTS - cnt);
			base = $urandom_range(0, lim - cnt);
			c[55:48] = {4'(cnt - 1), 4'(v0)};
			c[23:0] = {20'(base), 4'h0};
		end
		return c;
	endfunction

	function automatic logic [dlfe_pkg::CMD_W-1:0] random_triangle();
		logic [dlfe_pkg::CMD_W-1:0] c;
		int               t;
		c = {$urandom, $urandom};
		if ($urandom_range(2) == 0) begin
			c[63:56] = dlfe_pkg::OP_TRI1;
			for (t = 0; t < 3; t++)
				c[8*t +: 8] = ($urandom_range(9) == 0) ? 8'($urandom)
					: 8'($urandom_range(15) * 10 + $urandom_range(9));
		end else begin
			c[63:56] = dlfe_pkg::OP_TRI4;
			for (t = 0; t < dlfe_pkg::MAX_RESULTS; t++)
				if ($urandom_range(4) == 0) begin
					c[8*t +: 8] = 8'h00;
					if (t[0])
						c[36 + 8*(t/2) +: 4] = 4'h0;
					else
						c[32 + 8*(t/2) +: 4] = 4'h0;
				end
		end
		return c;
	endfunction

	function automatic logic [dlfe_pkg::CMD_W-1:0] random_kept();
		logic [dlfe_pkg::CMD_W-1:0] c;
		c = {$urandom, $urandom};
		case ($urandom_range(3))
			0: c[63:56] = dlfe_pkg::OP_NOOP;
			1: c[63:56] = dlfe_pkg::OP_SETGEO;
			2: c[63:56] = dlfe_pkg::OP_CLEARGEO;
			default: begin
				if (c[63:56] inside {dlfe_pkg::OP_VTX, dlfe_pkg::OP_TRI1,
						dlfe_pkg::OP_TRI4, dlfe_pkg::OP_END})
					c[63:56] = OP_OTHER;
			end
		endcase
		return c;
	endfunction

	task automatic test_empty_cache();
		send_command({dlfe_pkg::OP_TRI1, 56'h0}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'hF0, 48'h0}, 1'b0);
		send_command({dlfe_pkg::OP_NOOP, 56'h11_2233_4455_6677}, 1'b1);
	endtask

	task automatic test_vertex_loads();
		set_vertex_count(dlfe_pkg::CACHE_SLOTS);
		send_command({dlfe_pkg::OP_VTX, 8'hF0, 24'h0, 24'h000000}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'h00, 24'h0, 24'h000008}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'h00, 24'h0, 24'h000100}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'h80, 24'h0, 24'h000080}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'h88, 24'h0, 24'h000070}, 1'b0);
	endtask

	task automatic test_faces_and_groups();
		send_command({dlfe_pkg::OP_TRI1, 32'hFFFF_FFFF, 8'd9, 8'd19, 8'd159}, 1'b0);
		send_command({dlfe_pkg::OP_TRI1, 32'h0, 8'd160, 8'd0, 8'd255}, 1'b0);
		send_command({dlfe_pkg::OP_SETGEO, 24'h0, 32'h0000_2000}, 1'b0);
		send_command({dlfe_pkg::OP_NOOP, 24'hAB_CDEF, 32'h89AB_CDEF}, 1'b0);
		send_command({dlfe_pkg::OP_TRI4, 56'h00_D0_63_FE_00_54_21}, 1'b0);
		send_command({dlfe_pkg::OP_CLEARGEO, 24'hFF_FFFF, 32'hFFFF_DFFF}, 1'b0);
		send_command({dlfe_pkg::OP_TRI4, 56'hFF_FF_FF_FF_FF_FF_FF}, 1'b0);
		send_command({dlfe_pkg::OP_CLEARGEO, 24'h0, 32'h0000_2000}, 1'b1);
	endtask

	task automatic test_end_command();
		send_command({dlfe_pkg::OP_END, 56'h0}, 1'b0);
		send_command({dlfe_pkg::OP_TRI1, 32'h0, 8'd0, 8'd10, 8'd20}, 1'b1);
	endtask

	task automatic test_unfilled_slots();
		send_command({dlfe_pkg::OP_VTX, 8'h12, 24'h0, 24'h000050}, 1'b0);
		send_command({dlfe_pkg::OP_TRI4, 56'h00_00_30_00_00_32_32}, 1'b1);
	endtask

	task automatic test_table_edges();
		set_vertex_count(dlfe_pkg::MAX_VERTICES_DEF);
		send_command({dlfe_pkg::OP_VTX, 8'h0F, 24'h0, 24'h00FFF0}, 1'b0);
		send_command({dlfe_pkg::OP_TRI1, 32'h0, 8'd150, 8'd151, 8'd152}, 1'b0);
		send_command({dlfe_pkg::CMD_W{1'b1}}, 1'b1);
	endtask

	task automatic test_count_clamp();
		set_vertex_count((1 << dlfe_pkg::VC_W) - 1);
		send_command({dlfe_pkg::OP_VTX, 8'h00, 24'h0, 24'hFFFFF0}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'h00, 24'h0, 24'h010000}, 1'b0);
		send_command({dlfe_pkg::OP_VTX, 8'hF0, 24'h0, 24'h00FF00}, 1'b0);
		send_command({dlfe_pkg::OP_TRI1, 32'h0, 8'd0, 8'd10, 8'd150}, 1'b1);
	endtask

	// Mostly well-formed lists: a vertex load first, then faces, state changes and noise.
	task automatic test_random_traffic(input int phases, input bit idle);
		int               p;
		int               n;
		int               len;
		int               j;
		int unsigned      pick;
		logic [dlfe_pkg::CMD_W-1:0] c;
		for (p = 0; p < phases; p++) begin
			case ($urandom_range(3))
				0: set_vertex_count(dlfe_pkg::CACHE_SLOTS);
				1: set_vertex_count(dlfe_pkg::MAX_VERTICES_DEF);
				2: set_vertex_count($urandom_range(1, dlfe_pkg::CACHE_SLOTS - 1));
				default: set_vertex_count($urandom_range(dlfe_pkg::CACHE_SLOTS,
					dlfe_pkg::MAX_VERTICES_DEF));
			endcase
			idle_en = idle;
			n = 0;
			while (n < BURST_ITEMS) begin
				len = $urandom_range(3, 12);
				for (j = 0; j < len; j++) begin
					pick = $urandom_range(99);
					if (j == 0 || pick < 10)
						c = random_load();
					else if (pick < 60)
						c = random_triangle();
					else if (pick < 85)
						c = random_kept();
					else if (pick < 90)
						c = {dlfe_pkg::OP_END, 56'({$urandom, $urandom})};
					else
						c = {$urandom, $urandom};
					send_command(c, j == len - 1);
					n++;
				end
			end
		end
	endtask

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (predicted_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, res_data);
				errors++;
			end else begin
				head_result = predicted_results.pop_front();
				compare_field("result_kind", 64'(head_result.result_kind),
					64'(res_data.result_kind));
				compare_field("face_id", 64'(head_result.face_id), 64'(res_data.face_id));
				compare_field("vertex_a", 64'(head_result.vertex_a),
					64'(res_data.vertex_a));
				compare_field("vertex_b", 64'(head_result.vertex_b),
					64'(res_data.vertex_b));
				compare_field("vertex_c", 64'(head_result.vertex_c),
					64'(res_data.vertex_c));
				compare_field("draw_group", 64'(head_result.draw_group),
					64'(res_data.draw_group));
				compare_field("texture_high", 64'(head_result.texture_high),
					64'(res_data.texture_high));
				compare_field("texture_low", 64'(head_result.texture_low),
					64'(res_data.texture_low));
				compare_field("cull_back", 64'(head_result.cull_back),
					64'(res_data.cull_back));
				compare_field("kept_command", head_result.kept_command,
					res_data.kept_command);
				compare_field("last_result", 64'(head_result.last_result),
					64'(res_data.last_result));
			end
		end
	end

	always @(posedge clk)
		res_stall <= idle_en && ($urandom_range(99) < 23);

	always @(posedge clk) begin
		if (arst_n && ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		idle_en = 1'b1;
		vcount = '0;
		face_counter = 32'd1;
		clear_list();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_cache();
		test_vertex_loads();
		test_faces_and_groups();
		test_end_command();
		test_unfilled_slots();
		test_table_edges();
		test_count_clamp();
		test_random_traffic(4, 1'b1);
		test_random_traffic(3, 1'b0);

		wait_until_idle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/dlfe_pkg.sv
src/dlfe_decode.sv
src/dlfe_rqueue.sv
src/display_list_face_extractor.sv
tb/sv/tb.sv
